### rtl/mef_pkg.sv
// Shared types and constants of the majority element finder.
// No dependencies; every other file of the block imports this package.
package mef_pkg;

    // Store capacity and the widths that follow from it.
    localparam int MAX_ITEMS = 1024;
    localparam int ADDR_W    = $clog2(MAX_ITEMS);
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

    // Fixed field widths of the channels.
    localparam int DATA_W = 32;
    localparam int OCC_W  = 11;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_VERIFY,
        ST_FINISH
    } mef_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_en;   // input channel is open
        logic rd_issue;  // read the next stored element
        logic publish;   // load the result register and clear the array state
    } mef_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_end;    // every stored element has been read
        logic rd_pending;  // a read is in flight
        logic out_free;    // the result register can take a new result
    } mef_sts_t;

endpackage

### rtl/mef_if.sv
// Valid/ready channel interfaces of the majority element finder.
// Depends on mef_pkg for the field widths.
interface mef_in_if
    import mef_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] value;
    logic                     is_last;

    modport source (output valid, output value, output is_last, input ready);
    modport sink   (input valid, input value, input is_last, output ready);
endinterface

interface mef_out_if
    import mef_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] majority_value;
    logic                     found;
    logic        [OCC_W-1:0]  occurrences;
    logic                     overflow;

    modport source (output valid, output majority_value, output found,
                    output occurrences, output overflow, input ready);
    modport sink   (input valid, input majority_value, input found,
                    input occurrences, input overflow, output ready);
endinterface

### rtl/mef_datapath.sv
// Datapath of the majority element finder: element store, running vote,
// verify counter and result register. Depends on mef_pkg and mef_if.
module mef_datapath
    import mef_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  mef_cmd_t  cmd,
    output mef_sts_t  sts,
    output logic      in_accept,
    output logic      in_last,
    mef_in_if.sink    in_ch,
    mef_out_if.source out_ch
);

    logic [DATA_W-1:0] store_mem [MAX_ITEMS];
    logic [DATA_W-1:0] rd_data_reg;

    logic [DATA_W-1:0] candidate_reg, candidate_next;
    logic [CNT_W-1:0]  vote_count_reg, vote_count_next;
    logic [CNT_W-1:0]  item_count_reg, item_count_next;
    logic              dropped_reg, dropped_next;
    logic [CNT_W-1:0]  rd_idx_reg, rd_idx_next;
    logic              rd_pending_reg;
    logic [CNT_W-1:0]  hits_reg, hits_next;

    logic                     out_valid_reg, out_valid_next;
    logic signed [DATA_W-1:0] out_value_reg;
    logic                     out_found_reg;
    logic [OCC_W-1:0]         out_occ_reg;
    logic                     out_overflow_reg;

    logic has_room;
    logic store_en;
    logic found;

    assign in_ch.ready = cmd.load_en;
    assign in_accept   = in_ch.valid && cmd.load_en;
    assign in_last     = in_ch.is_last;
    assign has_room    = item_count_reg != CNT_W'(MAX_ITEMS);
    assign store_en    = in_accept && has_room;

    assign found = (item_count_reg != '0)
                && ({hits_reg, 1'b0} > {1'b0, item_count_reg});

    assign sts.scan_end   = rd_idx_reg == item_count_reg;
    assign sts.rd_pending = rd_pending_reg;
    assign sts.out_free   = !out_valid_reg || out_ch.ready;

    // Element store, one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (store_en)
        begin
            store_mem[item_count_reg[ADDR_W-1:0]] <= in_ch.value;
        end
        if (cmd.rd_issue)
        begin
            rd_data_reg <= store_mem[rd_idx_reg[ADDR_W-1:0]];
        end
    end

    always_comb
    begin
        candidate_next  = candidate_reg;
        vote_count_next = vote_count_reg;
        item_count_next = item_count_reg;
        dropped_next    = dropped_reg;
        rd_idx_next     = rd_idx_reg;
        hits_next       = hits_reg;
        out_valid_next  = out_valid_reg;

        if (out_ch.valid && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (store_en)
        begin
            item_count_next = item_count_reg + CNT_W'(1);
            if (vote_count_reg == '0)
            begin
                candidate_next  = in_ch.value;
                vote_count_next = CNT_W'(1);
            end
            else if (candidate_reg == in_ch.value)
            begin
                vote_count_next = vote_count_reg + CNT_W'(1);
            end
            else
            begin
                vote_count_next = vote_count_reg - CNT_W'(1);
            end
        end
        else if (in_accept)
        begin
            dropped_next = 1'b1;
        end

        if (cmd.rd_issue)
        begin
            rd_idx_next = rd_idx_reg + CNT_W'(1);
        end
        if (rd_pending_reg && (rd_data_reg == candidate_reg))
        begin
            hits_next = hits_reg + CNT_W'(1);
        end

        if (cmd.publish)
        begin
            out_valid_next  = 1'b1;
            vote_count_next = '0;
            item_count_next = '0;
            dropped_next    = 1'b0;
            rd_idx_next     = '0;
            hits_next       = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vote_count_reg <= '0;
            item_count_reg <= '0;
            dropped_reg    <= 1'b0;
            rd_idx_reg     <= '0;
            rd_pending_reg <= 1'b0;
            hits_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            vote_count_reg <= vote_count_next;
            item_count_reg <= item_count_next;
            dropped_reg    <= dropped_next;
            rd_idx_reg     <= rd_idx_next;
            rd_pending_reg <= cmd.rd_issue;
            hits_reg       <= hits_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // The candidate is only meaningful while the vote weight is nonzero.
    always_ff @(posedge clk)
    begin
        candidate_reg <= candidate_next;
        if (cmd.publish)
        begin
            out_value_reg    <= found ? candidate_reg : '0;
            out_found_reg    <= found;
            out_occ_reg      <= found ? OCC_W'(hits_reg) : '0;
            out_overflow_reg <= dropped_reg;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.majority_value = out_value_reg;
    assign out_ch.found          = out_found_reg;
    assign out_ch.occurrences    = out_occ_reg;
    assign out_ch.overflow       = out_overflow_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        item_count_reg <= CNT_W'(MAX_ITEMS))
        else $error("item count beyond store capacity");

    a_hits_bound: assert property (@(posedge clk) disable iff (!rst_n)
        hits_reg <= item_count_reg)
        else $error("verify count exceeds stored items");

    a_publish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |-> sts.out_free)
        else $error("result published over an untaken result");

    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_issue |-> !sts.scan_end)
        else $error("read issued past the stored items");

endmodule

### rtl/mef_ctrl.sv
// Controller state machine of the majority element finder.
// Depends on mef_pkg; drives the commands of mef_datapath.
module mef_ctrl
    import mef_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_accept,
    input  logic     in_last,
    input  mef_sts_t sts,
    output mef_cmd_t cmd
);

    mef_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_accept && in_last)
                begin
                    state_next = ST_VERIFY;
                end
            end
            ST_VERIFY:
            begin
                if (sts.scan_end && !sts.rd_pending)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_LOAD:
            begin
                cmd.load_en = 1'b1;
            end
            ST_VERIFY:
            begin
                cmd.rd_issue = !sts.scan_end;
            end
            ST_FINISH:
            begin
                cmd.publish = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/majority_element_finder.sv
// Top level of the majority element finder: controller plus datapath.
// Depends on mef_pkg, mef_if, mef_ctrl and mef_datapath.
//
// The block takes signed 32-bit values one beat at a time on in_ch, the beat
// with is_last high closing an array, and returns one result beat on out_ch
// per array: the value held by strictly more than half of the stored items
// with found set and its count in occurrences, or zeros when no such value
// exists. Up to 1024 values of an array are kept in an on-chip store; beats
// arriving with the store full are dropped and raise overflow on the result,
// and the majority is then judged over the stored values only. While an
// array loads, a running vote keeps the only possible winner, so input beats
// are taken one per cycle. After the closing beat the block rereads every
// stored element once through the store's single registered read port to
// count the winner: it issues one read per stored item, lets the last read
// data reach the count and waits for the count to settle, then publishes
// the result once the result register is free; in_ch is held not ready
// during the recount and the publish. A result sits in an output register
// until taken, so loading of the next array goes on meanwhile; only the
// publish of the following result waits for it.
// Store contents need no clearing after reset, since only entries written
// in the current array are read.
module majority_element_finder
    import mef_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    mef_in_if.sink    in_ch,
    mef_out_if.source out_ch
);

    mef_cmd_t cmd;
    mef_sts_t sts;
    logic     in_accept;
    logic     in_last;

    // Sequencing of load, recount and publish.
    mef_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_accept (in_accept),
        .in_last   (in_last),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Store, vote, recount and result register.
    mef_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_accept (in_accept),
        .in_last   (in_last),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

endmodule

### tb/mef_tb_pkg.sv
`timescale 1ns / 1ps
// Verdict type and the majority tracker that predicts and checks result beats.
// Depends on mef_pkg for the store capacity and the field widths.
package mef_tb_pkg;
    import mef_pkg::*;

    typedef logic signed [DATA_W-1:0] word_t;
    typedef word_t word_q_t[$];

    typedef struct packed {
        word_t              majority_value;
        logic               found;
        logic [OCC_W-1:0]   occurrences;
        logic               overflow;
    } verdict_t;

    class majority_tracker;
        word_t       stored[MAX_ITEMS];
        int unsigned fill;
        word_t       leader;
        int unsigned lead_margin;
        bit          lost_items;
        verdict_t    pending_verdicts[$];
        int unsigned mismatches;
        int unsigned verdicts_seen;
        int unsigned majorities_seen;
        int unsigned overflows_seen;

        function new();
            fill            = 0;
            leader          = '0;
            lead_margin     = 0;
            lost_items      = 1'b0;
            mismatches      = 0;
            verdicts_seen   = 0;
            majorities_seen = 0;
            overflows_seen  = 0;
        endfunction

        // Accepted input beat: store and vote, and on the closing beat recount
        // the leader over the stored elements to form the expected verdict.
        function void take_element(word_t value, logic is_last);
            int unsigned hits;
            verdict_t    verdict;
            if (fill < MAX_ITEMS) begin
                stored[fill] = value;
                fill++;
                if (lead_margin == 0) begin
                    leader      = value;
                    lead_margin = 1;
                end
                else if (leader == value)
                    lead_margin++;
                else
                    lead_margin--;
            end
            else
                lost_items = 1'b1;
            if (!is_last)
                return;
            hits = 0;
            for (int i = 0; i < fill; i++)
                if (stored[i] == leader)
                    hits++;
            verdict = '0;
            if (fill != 0 && 2 * hits > fill) begin
                verdict.majority_value = leader;
                verdict.found          = 1'b1;
                verdict.occurrences    = hits[OCC_W-1:0];
            end
            verdict.overflow = lost_items;
            pending_verdicts.push_back(verdict);
            fill        = 0;
            leader      = '0;
            lead_margin = 0;
            lost_items  = 1'b0;
        endfunction

        function void compare_field(string name, longint expected, longint actual);
            if (expected != actual) begin
                mismatches++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, expected, actual);
            end
        endfunction

        // Accepted result beat: compare it with the oldest expected verdict.
        function void check_verdict(verdict_t actual);
            verdict_t expected;
            verdicts_seen++;
            if (pending_verdicts.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result beat, expected none, actual %p",
                         $time, actual);
                return;
            end
            expected = pending_verdicts.pop_front();
            if (expected.found)
                majorities_seen++;
            if (expected.overflow)
                overflows_seen++;
            compare_field("majority_value", expected.majority_value, actual.majority_value);
            compare_field("found", expected.found, actual.found);
            compare_field("occurrences", expected.occurrences, actual.occurrences);
            compare_field("overflow", expected.overflow, actual.overflow);
        endfunction
    endclass

endpackage

### tb/majority_element_finder_test.sv
`timescale 1ns / 1ps
// Top level of the majority element finder testbench: clock, reset, stimulus.
// Depends on mef_pkg, mef_if, mef_tb_pkg and the majority_element_finder RTL.
module majority_element_finder_test;
    import mef_pkg::*;
    import mef_tb_pkg::*;

    // The slowest legal run is far below this: a few thousand elements plus
    // stall time on either side.
    localparam int CYCLE_LIMIT = 500000;

    // Items of random arrays sent in each idling phase.
    localparam int PHASE_BUDGET = 160;

    logic clk = 1'b0;
    logic rst_n;

    mef_in_if  in_ch ();
    mef_out_if out_ch ();

    majority_element_finder DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    majority_tracker tracker;

    int unsigned source_idle_pct = 0;
    int unsigned sink_stall_pct  = 0;
    int unsigned elements_sent   = 0;
    int unsigned arrays_sent     = 0;
    int unsigned cycle_count     = 0;

    // 8 ns clock period, 4 ns high and 4 ns low.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Every input of the block starts from a known value.
    initial
    begin
        rst_n          = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.value    = '0;
        in_ch.is_last  = 1'b0;
        out_ch.ready   = 1'b0;
        tracker        = new();
    end

    // Watchdog. A hung handshake or a missing result ends here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still awaited",
                     cycle_count, tracker.pending_verdicts.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result side. The ready line is redrawn on every falling edge, so stalls
    // land at any point of the block's work; a beat is taken at a rising edge
    // with valid and ready both high and checked right there.
    always @(negedge clk)
    begin
        out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            tracker.check_verdict({out_ch.majority_value, out_ch.found,
                                   out_ch.occurrences, out_ch.overflow});
    end

    // Mostly random 32-bit words, with the extremes of the signed range and
    // the all-zero and all-one patterns drawn now and then.
    function automatic word_t pick_value();
        case ($urandom_range(9))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Sends one element. The task is entered at a falling edge and returns at
    // the falling edge after the beat was taken. Valid stays high from one beat
    // to the next unless an idle gap is drawn, so valid never gets two updates
    // at the same edge.
    task automatic send_element(input word_t value, input logic is_last);
        if ($urandom_range(99) < source_idle_pct) begin
            in_ch.valid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < source_idle_pct);
        end
        in_ch.valid   <= 1'b1;
        in_ch.value   <= value;
        in_ch.is_last <= is_last;
        do
            @(posedge clk);
        while (!in_ch.ready);
        tracker.take_element(value, is_last);
        elements_sent++;
        @(negedge clk);
    endtask

    // Sends a whole array, marking its final element.
    task automatic send_array(input word_q_t elements);
        foreach (elements[i])
            send_element(elements[i], i == elements.size() - 1);
        arrays_sent++;
    endtask

    // Random array in one of three flavors. Most arrays favor one winner with
    // a bias drawn from 30 to 100 percent, so the verdict lands on both
    // sides of the strict-majority line; some draw from a pool of three values,
    // which gives ties and runner-up leaders; a few are plain random words.
    task automatic send_random_array(input int unsigned len);
        word_q_t     batch;
        word_t       winner;
        word_t       pool[3];
        int unsigned bias;
        int unsigned flavor;
        winner = pick_value();
        foreach (pool[k])
            pool[k] = pick_value();
        if ($urandom_range(3) == 0)
            pool[0] = winner;
        bias   = $urandom_range(100, 30);
        flavor = $urandom_range(9);
        for (int i = 0; i < len; i++) begin
            if (flavor < 7 && $urandom_range(99) < bias)
                batch.push_back(winner);
            else if (flavor < 9)
                batch.push_back(pool[$urandom_range(2)]);
            else
                batch.push_back(pick_value());
        end
        send_array(batch);
    endtask

    // Short arrays dominate; a few run long enough to stretch the recount.
    task automatic run_random_phase(input int unsigned idle_pct,
                                    input int unsigned stall_pct);
        int unsigned sent_here;
        int unsigned pick;
        source_idle_pct = idle_pct;
        sink_stall_pct  = stall_pct;
        sent_here       = 0;
        while (sent_here < PHASE_BUDGET) begin
            pick = $urandom_range(99);
            if (pick < 80)
                pick = $urandom_range(12, 1);
            else if (pick < 96)
                pick = $urandom_range(60, 13);
            else
                pick = $urandom_range(200, 61);
            send_random_array(pick);
            sent_here += pick;
        end
    endtask

    initial
    begin
        word_q_t batch;
        word_t   first_word;
        word_t   second_word;
        bit      failed;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed arrays, no idling on either side.
        // A single-element array is its own majority.
        send_array('{32'sh8000_0000});
        // Two of three is a majority, here at the top of the signed range.
        send_array('{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh0000_0000});
        // One of two is exactly half, which is not a majority.
        send_array('{32'shffff_ffff, 32'sh0000_0000});
        // An even tie between two values.
        send_array('{32'sh0000_0007, 32'sh0000_0007, 32'sh0000_0008, 32'sh0000_0008});
        // All distinct: the vote ends on a leader that the recount rejects.
        send_array('{32'sh0000_0001, 32'sh0000_0002, 32'sh0000_0003});
        // Alternating winner that loses the vote lead several times.
        send_array('{32'sh0000_0005, 32'sh0000_0009, 32'sh0000_0005,
                     32'sh0000_0009, 32'sh0000_0005});
        // Alternating bit patterns flip every bit of the value field.
        send_array('{32'shaaaa_aaaa, 32'sh5555_5555, 32'shaaaa_aaaa});

        // Full store with drops, the closing element among them. One value
        // fills every entry, which gives the largest possible occurrence
        // count, while the dropped elements carry another value that must
        // neither vote nor be counted.
        first_word  = $urandom;
        second_word = ~first_word;
        for (int i = 0; i < MAX_ITEMS + 3; i++)
            batch.push_back((i < MAX_ITEMS) ? first_word : second_word);
        send_array(batch);

        // The array after a drop starts clean, without the overflow mark.
        send_array('{32'sh0000_002a});

        // Random arrays under each idling mix.
        run_random_phase(0, 0);
        run_random_phase(79, 0);
        run_random_phase(0, 79);
        run_random_phase(38, 38);

        in_ch.valid <= 1'b0;
        while (tracker.pending_verdicts.size() != 0)
            @(posedge clk);
        // Wait for any stray result beat to show up.
        repeat (64) @(posedge clk);

        $display("Sent %0d arrays with %0d elements under four idle/stall mixes,",
                 arrays_sent, elements_sent);
        $display("checked %0d results: %0d with a majority, %0d with dropped elements",
                 tracker.verdicts_seen, tracker.majorities_seen, tracker.overflows_seen);
        failed = tracker.mismatches != 0 || tracker.pending_verdicts.size() != 0;
        if (!failed)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
